### src/pbfs_pkg.sv
// Shared types and codes for the protobuf field scanner.
// No dependencies; every other file refers to this package by scoped names.
package pbfs_pkg;

	// scanner phases
	localparam logic [2:0] PH_TAG  = 3'd0;
	localparam logic [2:0] PH_VAL  = 3'd1;
	localparam logic [2:0] PH_LEN  = 3'd2;
	localparam logic [2:0] PH_PAY  = 3'd3;
	localparam logic [2:0] PH_FIX  = 3'd4;
	localparam logic [2:0] PH_DISC = 3'd5;

	// event kinds
	localparam logic [2:0] EV_VARINT  = 3'd0;
	localparam logic [2:0] EV_HEADER  = 3'd1;
	localparam logic [2:0] EV_PAYLOAD = 3'd2;
	localparam logic [2:0] EV_FIXED   = 3'd3;
	localparam logic [2:0] EV_ERROR   = 3'd4;
	localparam logic [2:0] EV_END     = 3'd5;

	// error codes
	localparam logic [1:0] ERR_WIRE  = 2'd0;
	localparam logic [1:0] ERR_TRUNC = 2'd1;
	localparam logic [1:0] ERR_LONG  = 2'd2;

	// wire types
	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_FIX64  = 3'd1;
	localparam logic [2:0] WT_LEN    = 3'd2;
	localparam logic [2:0] WT_FIX32  = 3'd5;

	// varint feed status
	localparam logic [1:0] VI_MORE = 2'd0;
	localparam logic [1:0] VI_DONE = 2'd1;
	localparam logic [1:0] VI_LONG = 2'd2;

	localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;
	localparam logic [3:0] VARINT_LAST_SLOT = 4'd9;
	localparam logic [63:0] FIX64_BYTES = 64'd8;
	localparam logic [63:0] FIX32_BYTES = 64'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_beat_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [31:0] field_num;
		logic [2:0]  wire_kind;
		logic [63:0] value;
		logic [7:0]  payload_byte;
		logic [1:0]  error_code;
		logic        message_done;
	} event_beat_t;

	typedef struct packed {
		logic [2:0] phase;
		logic [3:0] varint_bytes;
	} dec_status_t;

	typedef struct packed {
		logic out_full;
		logic skid_full;
	} buf_status_t;

endpackage

### src/pbfs_varint.sv
// Varint byte folder: merges one byte into the running accumulator.
// Depends on pbfs_pkg.
module pbfs_varint (
	input  logic [63:0] acc,
	input  logic [3:0]  cnt,
	input  logic [7:0]  data,
	output logic [63:0] acc_nx,
	output logic [3:0]  cnt_nx,
	output logic [1:0]  status
);

	logic [3:0] slot;
	logic [5:0] sh;

	always_comb begin
		slot   = (cnt > pbfs_pkg::VARINT_LAST_SLOT) ? pbfs_pkg::VARINT_LAST_SLOT : cnt;
		sh     = {2'b00, slot} * 6'd7;
		acc_nx = acc | ({57'd0, data[6:0]} << sh);
		cnt_nx = cnt + 4'd1;
		if (!data[7]) begin
			status = pbfs_pkg::VI_DONE;
		end else if (cnt_nx >= pbfs_pkg::VARINT_MAX_BYTES) begin
			status = pbfs_pkg::VI_LONG;
		end else begin
			status = pbfs_pkg::VI_MORE;
		end
	end

endmodule

### src/pbfs_decode.sv
// Field scanner state machine: tag/value/length/payload/skip/discard phases.
// Depends on pbfs_pkg and pbfs_varint.
module pbfs_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  pbfs_pkg::byte_beat_t  beat,
	output logic                  res_valid,
	output pbfs_pkg::event_beat_t res,
	output pbfs_pkg::dec_status_t status
);

	logic [2:0]  phase_q, phase_d;
	logic [63:0] acc_q, acc_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [31:0] fld_q, fld_d;
	logic [2:0]  wire_q, wire_d;
	logic [63:0] rem_q, rem_d;

	logic [63:0] vi_acc;
	logic [3:0]  vi_cnt;
	logic [1:0]  vi_st;
	logic [63:0] rem_dec;
	logic [31:0] tag_field;
	logic [2:0]  tag_wire;
	logic        hit;
	logic        err_set;
	logic [1:0]  err_code;
	logic [31:0] err_field;
	logic [2:0]  err_wire;
	logic        last;

	pbfs_varint u_varint (
		.acc    (acc_q),
		.cnt    (cnt_q),
		.data   (beat.data_byte),
		.acc_nx (vi_acc),
		.cnt_nx (vi_cnt),
		.status (vi_st)
	);

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		cnt_d     = cnt_q;
		fld_d     = fld_q;
		wire_d    = wire_q;
		rem_d     = rem_q;
		hit       = 1'b0;
		res       = '0;
		err_set   = 1'b0;
		err_code  = pbfs_pkg::ERR_WIRE;
		err_field = '0;
		err_wire  = '0;
		last      = beat.last_byte;
		rem_dec   = rem_q - 64'd1;
		tag_field = vi_acc[34:3];
		tag_wire  = vi_acc[2:0];

		unique case (phase_q)
			pbfs_pkg::PH_VAL, pbfs_pkg::PH_LEN: begin
				acc_d = vi_acc;
				cnt_d = vi_cnt;
				err_field = fld_q;
				err_wire  = wire_q;
				if (vi_st == pbfs_pkg::VI_LONG) begin
					err_set  = 1'b1;
					err_code = pbfs_pkg::ERR_LONG;
				end else if (vi_st == pbfs_pkg::VI_MORE) begin
					if (last) begin
						err_set  = 1'b1;
						err_code = pbfs_pkg::ERR_TRUNC;
					end
				end else begin
					acc_d = '0;
					cnt_d = '0;
					res.field_num = fld_q;
					res.wire_kind = wire_q;
					if (phase_q == pbfs_pkg::PH_VAL) begin
						hit            = 1'b1;
						res.event_kind = pbfs_pkg::EV_VARINT;
						res.value      = vi_acc;
						phase_d        = pbfs_pkg::PH_TAG;
					end else if (vi_acc == 64'd0) begin
						hit            = 1'b1;
						res.event_kind = pbfs_pkg::EV_HEADER;
						phase_d        = pbfs_pkg::PH_TAG;
					end else if (last) begin
						err_set  = 1'b1;
						err_code = pbfs_pkg::ERR_TRUNC;
					end else begin
						hit            = 1'b1;
						res.event_kind = pbfs_pkg::EV_HEADER;
						res.value      = vi_acc;
						rem_d          = vi_acc;
						phase_d        = pbfs_pkg::PH_PAY;
					end
				end
			end
			pbfs_pkg::PH_PAY: begin
				rem_d     = rem_dec;
				err_field = fld_q;
				err_wire  = wire_q;
				if (rem_dec != 64'd0 && last) begin
					err_set  = 1'b1;
					err_code = pbfs_pkg::ERR_TRUNC;
				end else begin
					hit              = 1'b1;
					res.event_kind   = pbfs_pkg::EV_PAYLOAD;
					res.field_num    = fld_q;
					res.wire_kind    = wire_q;
					res.payload_byte = beat.data_byte;
					if (rem_dec == 64'd0) begin
						phase_d = pbfs_pkg::PH_TAG;
					end
				end
			end
			pbfs_pkg::PH_FIX: begin
				rem_d     = rem_dec;
				err_field = fld_q;
				err_wire  = wire_q;
				if (rem_dec == 64'd0) begin
					hit            = 1'b1;
					res.event_kind = pbfs_pkg::EV_FIXED;
					res.field_num  = fld_q;
					res.wire_kind  = wire_q;
					phase_d        = pbfs_pkg::PH_TAG;
				end else if (last) begin
					err_set  = 1'b1;
					err_code = pbfs_pkg::ERR_TRUNC;
				end
			end
			pbfs_pkg::PH_DISC: begin
				if (last) begin
					hit            = 1'b1;
					res.event_kind = pbfs_pkg::EV_END;
				end
			end
			default: begin
				// tag phase; unused codes land here too
				acc_d = vi_acc;
				cnt_d = vi_cnt;
				if (vi_st == pbfs_pkg::VI_LONG) begin
					err_set  = 1'b1;
					err_code = pbfs_pkg::ERR_LONG;
				end else if (vi_st == pbfs_pkg::VI_MORE) begin
					if (last) begin
						err_set  = 1'b1;
						err_code = pbfs_pkg::ERR_TRUNC;
					end
				end else begin
					acc_d     = '0;
					cnt_d     = '0;
					fld_d     = tag_field;
					wire_d    = tag_wire;
					err_field = tag_field;
					err_wire  = tag_wire;
					if (tag_wire != pbfs_pkg::WT_VARINT && tag_wire != pbfs_pkg::WT_FIX64 &&
					    tag_wire != pbfs_pkg::WT_LEN && tag_wire != pbfs_pkg::WT_FIX32) begin
						err_set  = 1'b1;
						err_code = pbfs_pkg::ERR_WIRE;
					end else if (last) begin
						err_set  = 1'b1;
						err_code = pbfs_pkg::ERR_TRUNC;
					end else if (tag_wire == pbfs_pkg::WT_VARINT) begin
						phase_d = pbfs_pkg::PH_VAL;
					end else if (tag_wire == pbfs_pkg::WT_LEN) begin
						phase_d = pbfs_pkg::PH_LEN;
					end else begin
						rem_d   = (tag_wire == pbfs_pkg::WT_FIX64) ?
						          pbfs_pkg::FIX64_BYTES : pbfs_pkg::FIX32_BYTES;
						phase_d = pbfs_pkg::PH_FIX;
					end
				end
			end
		endcase

		if (err_set) begin
			hit            = 1'b1;
			res            = '0;
			res.event_kind = pbfs_pkg::EV_ERROR;
			res.field_num  = err_field;
			res.wire_kind  = err_wire;
			res.error_code = err_code;
			acc_d          = '0;
			cnt_d          = '0;
			phase_d        = pbfs_pkg::PH_DISC;
		end

		// every result carries the end-of-message flag of its byte
		res.message_done = last;

		if (last) begin
			phase_d = pbfs_pkg::PH_TAG;
			acc_d   = '0;
			cnt_d   = '0;
			fld_d   = '0;
			wire_d  = '0;
			rem_d   = '0;
		end
	end

	assign res_valid     = accept && hit;
	assign status.phase  = phase_q;
	assign status.varint_bytes = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pbfs_pkg::PH_TAG;
			acc_q   <= '0;
			cnt_q   <= '0;
			fld_q   <= '0;
			wire_q  <= '0;
			rem_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			fld_q   <= fld_d;
			wire_q  <= wire_d;
			rem_q   <= rem_d;
		end
	end

endmodule

### src/pbfs_outbuf.sv
// Event output register with one skid entry behind it.
// Depends on pbfs_pkg.
module pbfs_outbuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pbfs_pkg::event_beat_t push_beat,
	output logic                  event_valid,
	input  logic                  event_stall,
	output pbfs_pkg::event_beat_t event_beat,
	output pbfs_pkg::buf_status_t status
);

	logic                  out_vld_q;
	logic                  skid_vld_q;
	pbfs_pkg::event_beat_t out_q;
	pbfs_pkg::event_beat_t skid_q;
	logic                  drain;

	assign drain = !out_vld_q || !event_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (drain) begin
			out_vld_q  <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	// push only arrives while the skid entry is empty
	always_ff @(posedge clk) begin
		if (drain) begin
			out_q <= skid_vld_q ? skid_q : push_beat;
		end else if (push) begin
			skid_q <= push_beat;
		end
	end

	assign event_valid      = out_vld_q;
	assign event_beat       = out_q;
	assign status.out_full  = out_vld_q;
	assign status.skid_full = skid_vld_q;

endmodule

### src/protobuf_field_scanner_core.sv
// Top level of the protobuf field scanner: byte input channel, event output channel.
// Depends on pbfs_pkg, pbfs_decode (with pbfs_varint) and pbfs_outbuf.
//
// Scans one level of a serialized protobuf message at one byte per clock, sustained while
// byte_stall is low. Each accepted byte is decoded in the same cycle it is taken: the tag,
// value and length varints are folded into a 64-bit accumulator, payload and fixed-width
// fields count down a 64-bit remaining-bytes register, and any event the byte causes is
// written into the output register or its skid entry. That combinational step
// (varint shift-merge plus 64-bit decrement and compare) sets the one-byte-per-clock
// figure. A byte yields zero or one event; bytes inside a varint or a skipped fixed field
// yield none, and every byte flagged last_byte yields exactly one, after which the scanner
// is back at a tag boundary with clean state. Errors (unknown wire type, overlong varint,
// truncated message) are reported once; the rest of that message is dropped up to a
// message-end event. A single skid entry sits behind the output register, so an event can
// wait downstream while the next byte is taken; byte_stall rises only when both are full.
// No clearing pass after reset.
module protobuf_field_scanner_core (
	input  logic                  clk,
	input  logic                  arst_n,
	// byte channel
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  pbfs_pkg::byte_beat_t  byte_beat,
	// event channel
	output logic                  event_valid,
	input  logic                  event_stall,
	output pbfs_pkg::event_beat_t event_beat
);

	logic                  accept;
	logic                  res_valid;
	pbfs_pkg::event_beat_t res;
	pbfs_pkg::dec_status_t dec_stat;
	pbfs_pkg::buf_status_t buf_stat;

	// stall is a registered flag, so the upstream path sees no combinational loop
	assign byte_stall = buf_stat.skid_full;
	assign accept     = byte_valid && !byte_stall;

	pbfs_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.beat      (byte_beat),
		.res_valid (res_valid),
		.res       (res),
		.status    (dec_stat)
	);

	pbfs_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (res_valid),
		.push_beat   (res),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_beat  (event_beat),
		.status      (buf_stat)
	);

`ifndef SYNTH
	// every last byte of a message produces an event
	a_last_gives_event: assert property (@(posedge clk) disable iff (!arst_n)
		accept && byte_beat.last_byte |-> res_valid)
		else $error("last byte produced no event");

	// after a message ends the scanner restarts at a tag with an empty varint
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && byte_beat.last_byte |=>
		dec_stat.phase == pbfs_pkg::PH_TAG && dec_stat.varint_bytes == 4'd0)
		else $error("state not cleared after message end");

	// the stored varint byte count never reaches the overlong limit
	a_varint_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dec_stat.varint_bytes < pbfs_pkg::VARINT_MAX_BYTES)
		else $error("varint byte count out of range");

	// the skid entry is only ever occupied behind a full output register
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		buf_stat.skid_full |-> buf_stat.out_full)
		else $error("skid entry full while output register empty");
`endif

endmodule

### bench/tb.sv
// Self-checking bench for protobuf_field_scanner_core: byte stream in, field events out.
// Depends on pbfs_pkg for the beat types and the phase, event, error and wire-type codes.
`timescale 1ns / 100ps

module tb;

	// wire types the scanner must reject
	localparam logic [2:0] WT_GROUP_START = 3'd3;
	localparam logic [2:0] WT_GROUP_END   = 3'd4;
	localparam logic [2:0] WT_RESERVED_6  = 3'd6;
	localparam logic [2:0] WT_RESERVED_7  = 3'd7;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BYTES = 2000;
	localparam int DRAIN_CYCLES = 8;

	localparam pbfs_pkg::event_beat_t NO_EVENT = '0;

	// one directed byte; has_ev marks rows whose event is written out by hand
	typedef struct packed {
		logic [7:0]            data;
		logic                  last;
		logic                  has_ev;
		pbfs_pkg::event_beat_t ev;
	} stim_row_t;

	localparam int N_DIRECTED = 27;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		// lone tag byte flagged last: truncated right after reset
		'{8'h08, 1'b1, 1'b1, '{pbfs_pkg::EV_ERROR, 32'd1, pbfs_pkg::WT_VARINT, 64'd0, 8'd0,
			pbfs_pkg::ERR_TRUNC, 1'b1}},
		// field 1 varint 150
		'{8'h08, 1'b0, 1'b0, NO_EVENT},
		'{8'h96, 1'b0, 1'b0, NO_EVENT},
		'{8'h01, 1'b0, 1'b0, NO_EVENT},
		// field 2, zero length header goes straight back to tag
		'{8'h12, 1'b0, 1'b0, NO_EVENT},
		'{8'h00, 1'b0, 1'b0, NO_EVENT},
		// wire type 7 on the last byte: bad wire type wins over truncation
		'{8'h0F, 1'b1, 1'b1, '{pbfs_pkg::EV_ERROR, 32'd1, WT_RESERVED_7, 64'd0, 8'd0,
			pbfs_pkg::ERR_WIRE, 1'b1}},
		// ten continuation bytes in a tag, the tenth flagged last: overlong wins
		'{8'hFF, 1'b0, 1'b0, NO_EVENT},
		'{8'hFF, 1'b0, 1'b0, NO_EVENT},
		'{8'hFF, 1'b0, 1'b0, NO_EVENT},
		'{8'hFF, 1'b0, 1'b0, NO_EVENT},
		'{8'hFF, 1'b0, 1'b0, NO_EVENT},
		'{8'hFF, 1'b0, 1'b0, NO_EVENT},
		'{8'hFF, 1'b0, 1'b0, NO_EVENT},
		'{8'hFF, 1'b0, 1'b0, NO_EVENT},
		'{8'hFF, 1'b0, 1'b0, NO_EVENT},
		'{8'hFF, 1'b1, 1'b1, '{pbfs_pkg::EV_ERROR, 32'd0, 3'd0, 64'd0, 8'd0,
			pbfs_pkg::ERR_LONG, 1'b1}},
		// start-group wire type mid message, then the discarded tail ends it
		'{8'h0B, 1'b0, 1'b1, '{pbfs_pkg::EV_ERROR, 32'd1, WT_GROUP_START, 64'd0, 8'd0,
			pbfs_pkg::ERR_WIRE, 1'b0}},
		'{8'h00, 1'b1, 1'b1, '{pbfs_pkg::EV_END, 32'd0, 3'd0, 64'd0, 8'd0, 2'd0, 1'b1}},
		// field 3, one payload byte
		'{8'h1A, 1'b0, 1'b0, NO_EVENT},
		'{8'h01, 1'b0, 1'b0, NO_EVENT},
		'{8'hFF, 1'b0, 1'b0, NO_EVENT},
		// fixed32 skipped, its last byte closes the message
		'{8'h0D, 1'b0, 1'b0, NO_EVENT},
		'{8'h00, 1'b0, 1'b0, NO_EVENT},
		'{8'hFF, 1'b0, 1'b0, NO_EVENT},
		'{8'h80, 1'b0, 1'b0, NO_EVENT},
		'{8'h7F, 1'b1, 1'b0, NO_EVENT}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  byte_valid;
	logic                  byte_stall;
	pbfs_pkg::byte_beat_t  byte_beat;
	logic                  event_valid;
	logic                  event_stall = 1'b0;
	pbfs_pkg::event_beat_t event_beat;

	protobuf_field_scanner_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_beat   (byte_beat),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_beat  (event_beat)
	);

	initial forever #5 clk = ~clk;

	// scanner state as the bench tracks it
	logic [2:0]  sc_phase;
	logic [63:0] sc_acc;
	logic [3:0]  sc_nbytes;
	logic [31:0] sc_field;
	logic [2:0]  sc_wire;
	logic [63:0] sc_left;

	pbfs_pkg::event_beat_t pending_events [$];   // events still owed by the scanner, oldest first
	pbfs_pkg::event_beat_t want_ev;
	logic [7:0]  msg_bytes [$];        // message being assembled for the random part

	int  live_bytes = 0;    // bytes taken outside the discard phase
	int  events_seen = 0;
	int  mismatches = 0;
	int  cycles = 0;
	bit  tx_calm = 1'b0;    // sender never idles while set
	bit  rx_calm = 1'b0;    // receiver never stalls while set

	function automatic void clear_scanner();
		sc_phase  = pbfs_pkg::PH_TAG;
		sc_acc    = '0;
		sc_nbytes = '0;
		sc_field  = '0;
		sc_wire   = '0;
		sc_left   = '0;
	endfunction

	// merge one byte into the varint accumulator; past the tenth slot bits fall off the top
	function automatic logic [1:0] fold_varint(logic [7:0] b);
		logic [3:0] slot;
		slot = (sc_nbytes > pbfs_pkg::VARINT_LAST_SLOT) ? pbfs_pkg::VARINT_LAST_SLOT : sc_nbytes;
		sc_acc |= 64'(b[6:0]) << (7 * slot);
		sc_nbytes = sc_nbytes + 4'd1;
		if (!b[7])
			return pbfs_pkg::VI_DONE;
		if (sc_nbytes >= pbfs_pkg::VARINT_MAX_BYTES)
			return pbfs_pkg::VI_LONG;
		return pbfs_pkg::VI_MORE;
	endfunction

	function automatic pbfs_pkg::event_beat_t error_event(logic [1:0] code, logic [31:0] fld,
			logic [2:0] wt, logic last);
		sc_acc    = '0;
		sc_nbytes = '0;
		sc_phase  = last ? pbfs_pkg::PH_TAG : pbfs_pkg::PH_DISC;
		return '{pbfs_pkg::EV_ERROR, fld, wt, 64'd0, 8'd0, code, last};
	endfunction

	// advance the tracked state by one byte; hit says whether an event comes out
	function automatic void scan_byte(input logic [7:0] b, input logic last,
			output logic hit, output pbfs_pkg::event_beat_t ev);
		logic [1:0]  st;
		logic [63:0] word;
		hit = 1'b0;
		ev  = '0;
		case (sc_phase)
			pbfs_pkg::PH_VAL, pbfs_pkg::PH_LEN: begin
				st = fold_varint(b);
				if (st == pbfs_pkg::VI_LONG) begin
					hit = 1'b1;
					ev  = error_event(pbfs_pkg::ERR_LONG, sc_field, sc_wire, last);
				end else if (st == pbfs_pkg::VI_MORE) begin
					if (last) begin
						hit = 1'b1;
						ev  = error_event(pbfs_pkg::ERR_TRUNC, sc_field, sc_wire, last);
					end
				end else begin
					word      = sc_acc;
					sc_acc    = '0;
					sc_nbytes = '0;
					hit       = 1'b1;
					if (sc_phase == pbfs_pkg::PH_VAL) begin
						ev = '{pbfs_pkg::EV_VARINT, sc_field, sc_wire, word, 8'd0, 2'd0, last};
						sc_phase = pbfs_pkg::PH_TAG;
					end else if (word == 64'd0) begin
						ev = '{pbfs_pkg::EV_HEADER, sc_field, sc_wire, 64'd0, 8'd0, 2'd0, last};
						sc_phase = pbfs_pkg::PH_TAG;
					end else if (last) begin
						// header on the last byte leaves the payload missing
						ev = error_event(pbfs_pkg::ERR_TRUNC, sc_field, sc_wire, last);
					end else begin
						ev = '{pbfs_pkg::EV_HEADER, sc_field, sc_wire, word, 8'd0, 2'd0, 1'b0};
						sc_left  = word;
						sc_phase = pbfs_pkg::PH_PAY;
					end
				end
			end
			pbfs_pkg::PH_PAY: begin
				sc_left = sc_left - 64'd1;
				hit     = 1'b1;
				if (sc_left == 64'd0) begin
					ev = '{pbfs_pkg::EV_PAYLOAD, sc_field, sc_wire, 64'd0, b, 2'd0, last};
					sc_phase = pbfs_pkg::PH_TAG;
				end else if (last) begin
					ev = error_event(pbfs_pkg::ERR_TRUNC, sc_field, sc_wire, last);
				end else begin
					ev = '{pbfs_pkg::EV_PAYLOAD, sc_field, sc_wire, 64'd0, b, 2'd0, 1'b0};
				end
			end
			pbfs_pkg::PH_FIX: begin
				sc_left = sc_left - 64'd1;
				if (sc_left == 64'd0) begin
					hit = 1'b1;
					ev  = '{pbfs_pkg::EV_FIXED, sc_field, sc_wire, 64'd0, 8'd0, 2'd0, last};
					sc_phase = pbfs_pkg::PH_TAG;
				end else if (last) begin
					hit = 1'b1;
					ev  = error_event(pbfs_pkg::ERR_TRUNC, sc_field, sc_wire, last);
				end
			end
			pbfs_pkg::PH_DISC: begin
				if (last) begin
					hit = 1'b1;
					ev  = '{pbfs_pkg::EV_END, 32'd0, 3'd0, 64'd0, 8'd0, 2'd0, 1'b1};
				end
			end
			default: begin
				// tag phase; unused phase codes land here too
				st = fold_varint(b);
				if (st == pbfs_pkg::VI_LONG) begin
					hit = 1'b1;
					ev  = error_event(pbfs_pkg::ERR_LONG, 32'd0, 3'd0, last);
				end else if (st == pbfs_pkg::VI_MORE) begin
					if (last) begin
						hit = 1'b1;
						ev  = error_event(pbfs_pkg::ERR_TRUNC, 32'd0, 3'd0, last);
					end
				end else begin
					sc_field  = sc_acc[34:3];
					sc_wire   = sc_acc[2:0];
					sc_acc    = '0;
					sc_nbytes = '0;
					if (!(sc_wire inside {pbfs_pkg::WT_VARINT, pbfs_pkg::WT_FIX64,
							pbfs_pkg::WT_LEN, pbfs_pkg::WT_FIX32})) begin
						hit = 1'b1;
						ev  = error_event(pbfs_pkg::ERR_WIRE, sc_field, sc_wire, last);
					end else if (last) begin
						hit = 1'b1;
						ev  = error_event(pbfs_pkg::ERR_TRUNC, sc_field, sc_wire, last);
					end else begin
						case (sc_wire)
							pbfs_pkg::WT_VARINT: sc_phase = pbfs_pkg::PH_VAL;
							pbfs_pkg::WT_LEN:    sc_phase = pbfs_pkg::PH_LEN;
							pbfs_pkg::WT_FIX64: begin
								sc_left  = pbfs_pkg::FIX64_BYTES;
								sc_phase = pbfs_pkg::PH_FIX;
							end
							default: begin
								sc_left  = pbfs_pkg::FIX32_BYTES;
								sc_phase = pbfs_pkg::PH_FIX;
							end
						endcase
					end
				end
			end
		endcase
		if (last)
			clear_scanner();
	endfunction

	// ---------------------------------------------------------------- message builder

	function automatic logic [63:0] rand_wide();
		return {$urandom, $urandom} >> $urandom_range(63);
	endfunction

	// LEB128 encode; now and then padded with redundant continuation bytes
	function automatic void put_varint(logic [63:0] v);
		int n;
		logic [7:0] b;
		n = 1;
		while (n < 10 && (v >> (7 * n)) != 0)
			n++;
		if ($urandom_range(7) == 0)
			n = $urandom_range(n, 10);
		for (int i = 0; i < n; i++) begin
			b = {i < n - 1, 7'(v >> (7 * i))};
			if (i == 9)
				b[6:1] = 6'($urandom);   // beyond bit 63, must be dropped
			msg_bytes = {msg_bytes, b};
		end
	endfunction

	// append one field; returns 1 when the field leaves the message broken
	function automatic bit put_field();
		logic [63:0] fnum;
		logic [63:0] word;
		logic [2:0]  wt;
		int pick;
		int n;
		pick = $urandom_range(99);
		case ($urandom_range(9))
			0:       fnum = 64'($urandom);
			1:       fnum = rand_wide();      // upper tag bits truncate the field number
			default: fnum = 64'($urandom_range(1, 40));
		endcase
		if (pick < 30) begin
			put_varint((fnum << 3) | 64'(pbfs_pkg::WT_VARINT));
			put_varint(rand_wide());
			return 1'b0;
		end
		if (pick < 55) begin
			put_varint((fnum << 3) | 64'(pbfs_pkg::WT_LEN));
			n = $urandom_range(9);
			if (n == 0) begin
				// absurd length: message ends inside the payload
				put_varint(rand_wide() | 64'h100);
				repeat ($urandom_range(5))
					msg_bytes = {msg_bytes, 8'($urandom)};
				return 1'b1;
			end
			word = (n < 3) ? 64'($urandom_range(7, 40)) : 64'($urandom_range(0, 6));
			put_varint(word);
			repeat (word)
				msg_bytes = {msg_bytes, 8'($urandom)};
			return 1'b0;
		end
		if (pick < 85) begin
			wt = (pick < 70) ? pbfs_pkg::WT_FIX64 : pbfs_pkg::WT_FIX32;
			put_varint((fnum << 3) | 64'(wt));
			repeat ((wt == pbfs_pkg::WT_FIX64) ? 8 : 4)
				msg_bytes = {msg_bytes, 8'($urandom)};
			return 1'b0;
		end
		if (pick < 92) begin
			case ($urandom_range(3))
				0:       wt = WT_GROUP_START;
				1:       wt = WT_GROUP_END;
				2:       wt = WT_RESERVED_6;
				default: wt = WT_RESERVED_7;
			endcase
			put_varint((fnum << 3) | 64'(wt));
			repeat ($urandom_range(3))
				msg_bytes = {msg_bytes, 8'($urandom)};
			return 1'b1;
		end
		// overlong varint as tag, value or length
		n = $urandom_range(2);
		if (n == 1)
			put_varint((fnum << 3) | 64'(pbfs_pkg::WT_VARINT));
		if (n == 2)
			put_varint((fnum << 3) | 64'(pbfs_pkg::WT_LEN));
		repeat (10)
			msg_bytes = {msg_bytes, 8'h80 | 8'($urandom)};
		repeat ($urandom_range(3))
			msg_bytes = {msg_bytes, 8'($urandom)};
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- byte channel

	// present one beat, hold it until taken, then book the event it owes
	task automatic offer_byte(input logic [7:0] b, input logic last, input logic typed,
			input pbfs_pkg::event_beat_t typed_ev);
		logic hit;
		pbfs_pkg::event_beat_t ev;
		while (!tx_calm && $urandom_range(99) < 20) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_beat  <= '{b, last};
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		if (sc_phase != pbfs_pkg::PH_DISC)
			live_bytes++;
		scan_byte(b, last, hit, ev);
		if (typed)
			pending_events = {pending_events, typed_ev};
		else if (hit)
			pending_events = {pending_events, ev};
	endtask

	// ---------------------------------------------------------------- event channel

	always @(posedge clk)
		event_stall <= rx_calm ? 1'b0 : ($urandom_range(99) < 20);

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%t event %0d: %s expected 0x%0h got 0x%0h",
					$time, events_seen, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && event_valid && !event_stall) begin
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t unexpected event kind %0d", $time, event_beat.event_kind);
			end else begin
				want_ev = pending_events.pop_front();
				check_field("event_kind", 64'(want_ev.event_kind),
					64'(event_beat.event_kind));
				check_field("field_num", 64'(want_ev.field_num),
					64'(event_beat.field_num));
				check_field("wire_kind", 64'(want_ev.wire_kind),
					64'(event_beat.wire_kind));
				check_field("value", want_ev.value, event_beat.value);
				check_field("payload_byte", 64'(want_ev.payload_byte),
					64'(event_beat.payload_byte));
				check_field("error_code", 64'(want_ev.error_code),
					64'(event_beat.error_code));
				check_field("message_done", 64'(want_ev.message_done),
					64'(event_beat.message_done));
			end
			events_seen++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int m;
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		byte_beat  = '0;
		clear_scanner();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			offer_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].has_ev, DIRECTED[i].ev);

		// random messages: mostly well-formed fields, some noise, some cut short
		m = 0;
		while (live_bytes < RANDOM_BYTES) begin
			tx_calm = (m >= 50 && m < 90);
			rx_calm = tx_calm;
			if (m == 30) begin
				// hold off until the scanner has delivered everything
				byte_valid <= 1'b0;
				@(posedge clk);
				while (pending_events.size() != 0)
					@(posedge clk);
			end
			msg_bytes.delete();
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 12))
					msg_bytes = {msg_bytes, 8'($urandom)};
			end else begin
				repeat ($urandom_range(1, 5))
					if (put_field())
						break;
				if ($urandom_range(6) == 0 && msg_bytes.size() > 1)
					repeat ($urandom_range(1, msg_bytes.size() - 1))
						void'(msg_bytes.pop_back());
			end
			for (int i = 0; i < msg_bytes.size(); i++)
				offer_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, NO_EVENT);
			m++;
		end

		tx_calm = 1'b0;
		rx_calm = 1'b0;
		byte_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_events.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### sim.f
src/pbfs_pkg.sv
src/pbfs_varint.sv
src/pbfs_decode.sv
src/pbfs_outbuf.sv
src/protobuf_field_scanner_core.sv
bench/tb.sv
